>>> design/rrp_pkg.sv
// rrp_pkg: shared types and constants for the regulator redundancy pruner.
// No dependencies.
package rrp_pkg;
    localparam int CHUNK_GENES = 64;
    localparam int MAX_CHUNKS  = 16;
    localparam int DEGREE_LIMIT = 2;
    localparam int CFG_NUM_GENES = 0;
    localparam int CFG_NUM_REGS  = 1;

    typedef struct packed {
        logic load;       // store a row and update degree / subset state
        logic clr_run;    // clear per-run state
        logic reg_start;  // begin regulator walk
        logic reg_step;   // evaluate one (i, j) pair
        logic gene_rd;    // issue one row read for gene mask
        logic gene_cap;   // capture returned row data
        logic chunk_clr;  // clear chunk accumulator
    } rrp_cmd_t;

    typedef struct packed {
        logic run_done;   // rows_loaded, counting a row stored this cycle, reached effective gene count
        logic reg_done;   // regulator walk finished
        logic chunk_full; // current chunk has all its genes read
        logic genes_done; // no more reads for the current chunk
        logic last;       // current chunk is the final one
    } rrp_sts_t;
endpackage

>>> design/rrp_datapath.sv
// rrp_datapath: row memory, degree counters, subset vectors, regulator walk and
// gene chunk assembly. Depends on rrp_pkg.
module rrp_datapath #(
    parameter int MAX_REGS  = 32,
    parameter int MAX_GENES = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  rrp_pkg::rrp_cmd_t cmd,
    output rrp_pkg::rrp_sts_t sts,
    input  logic [10:0]      num_genes,
    input  logic [5:0]       num_regs,
    input  logic [31:0]      edge_row,
    output logic [31:0]      removed_mask,
    output logic [63:0]      chunk_bits,
    output logic [3:0]       chunk_idx
);
    import rrp_pkg::*;

    localparam int RW = (MAX_REGS < 32) ? MAX_REGS : 32;
    localparam int IW = $clog2(RW);
    localparam int AW = $clog2(MAX_GENES);
    localparam int CW = AW + 1;

    logic [31:0]  mem [MAX_GENES];
    logic [31:0]  rd_data_reg;
    logic [CW-1:0] rows_loaded_reg;
    logic [10:0]  deg_reg [RW];
    logic [31:0]  nsb_reg [RW];
    logic [IW-1:0] i_reg, j_reg;
    logic         reg_done_reg;
    logic [31:0]  removed_reg;
    logic [CW-1:0] gene_reg;
    logic [CW-1:0] cap_gene_reg;
    logic [63:0]  bits_reg;
    logic [3:0]   chunk_reg;

    logic [6:0]   n_regs;
    logic [31:0]  used;
    logic [CW-1:0] m_genes;
    logic [31:0]  row;

    always_comb begin
        n_regs = (num_regs > 6'(RW)) ? 7'(RW) : {1'b0, num_regs};
        used = (n_regs >= 7'd32) ? '1 : ((32'd1 << n_regs[4:0]) - 32'd1);
        if (num_genes == '0) m_genes = CW'(1);
        else if (32'(num_genes) > MAX_GENES) m_genes = CW'(MAX_GENES);
        else m_genes = CW'(num_genes);
        row = edge_row & used;
    end

    logic loaded_now;
    assign loaded_now = cmd.load && (32'(rows_loaded_reg) < MAX_GENES);

    always_ff @(posedge aclk) begin
        if (loaded_now) mem[rows_loaded_reg[AW-1:0]] <= row;
        if (cmd.gene_rd) rd_data_reg <= mem[gene_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr_run) begin
            rows_loaded_reg <= '0;
            for (int k = 0; k < RW; k++) begin
                deg_reg[k] <= '0;
                nsb_reg[k] <= '0;
            end
        end else if (loaded_now) begin
            rows_loaded_reg <= rows_loaded_reg + CW'(1);
            for (int k = 0; k < RW; k++) begin
                if (row[k]) begin
                    deg_reg[k] <= deg_reg[k] + 11'd1;
                    nsb_reg[k] <= nsb_reg[k] | (~row & used);
                end
            end
        end
    end

    // Regulator walk: i from n-1 down, j from n-1 down per i.
    logic [IW-1:0] n_last;
    logic          i_pruned_deg, j_hit;
    logic [31:0]   i_bit;
    assign n_last = IW'(n_regs - 7'd1);
    assign i_bit = 32'd1 << i_reg;
    assign i_pruned_deg = deg_reg[i_reg] <= 11'(DEGREE_LIMIT);
    assign j_hit = (j_reg != i_reg) && !removed_reg[j_reg] && !nsb_reg[i_reg][j_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            removed_reg <= '0;
            reg_done_reg <= 1'b0;
            i_reg <= '0;
            j_reg <= '0;
        end else if (cmd.reg_start) begin
            removed_reg <= '0;
            i_reg <= n_last;
            j_reg <= n_last;
            reg_done_reg <= (n_regs == 7'd0);
        end else if (cmd.reg_step && !reg_done_reg) begin
            if (i_pruned_deg || j_hit || j_reg == '0) begin
                if (i_pruned_deg || j_hit) removed_reg <= removed_reg | i_bit;
                if (i_reg == '0) reg_done_reg <= 1'b1;
                i_reg <= i_reg - IW'(1);
                j_reg <= n_last;
            end else begin
                j_reg <= j_reg - IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.reg_start) begin
            gene_reg <= '0;
            cap_gene_reg <= '0;
            chunk_reg <= '0;
            bits_reg <= '0;
        end else begin
            if (cmd.gene_rd) gene_reg <= gene_reg + CW'(1);
            if (cmd.chunk_clr) begin
                bits_reg <= '0;
                chunk_reg <= chunk_reg + 4'd1;
            end
            if (cmd.gene_cap) begin
                cap_gene_reg <= cap_gene_reg + CW'(1);
                if ((rd_data_reg & ~removed_reg & used) == '0)
                    bits_reg[cap_gene_reg[5:0]] <= 1'b1;
            end
        end
    end

    logic [CW-1:0] lim;
    assign lim = (32'(m_genes) > CHUNK_GENES * MAX_CHUNKS)
               ? CW'(CHUNK_GENES * MAX_CHUNKS) : m_genes;

    always_comb begin
        sts.run_done   = (32'(rows_loaded_reg) + (loaded_now ? 1 : 0)) >= 32'(m_genes);
        sts.reg_done   = reg_done_reg;
        sts.genes_done = (gene_reg >= lim)
                         || (32'(gene_reg) >= (32'(chunk_reg) + 1) * CHUNK_GENES);
        sts.chunk_full = (cap_gene_reg >= lim) || (cap_gene_reg[5:0] == 6'd0
                         && cap_gene_reg != '0 && 32'(cap_gene_reg) > 32'(chunk_reg) * 64);
        sts.last       = (cap_gene_reg >= lim);
    end

    assign removed_mask = removed_reg;
    assign chunk_bits = bits_reg;
    assign chunk_idx = chunk_reg;
endmodule

>>> design/rrp_ctrl.sv
// rrp_ctrl: sequencing FSM for load, regulator walk, and chunk output.
// Depends on rrp_pkg.
module rrp_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_last,
    output rrp_pkg::rrp_cmd_t cmd,
    input  rrp_pkg::rrp_sts_t sts
);
    import rrp_pkg::*;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_REGS = 3'd1;
    localparam logic [2:0] S_GENE = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;
    localparam logic [2:0] S_START = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       pend_reg, pend_next;
    logic       last_reg, last_next;

    always_comb begin
        state_next = state_reg;
        pend_next = 1'b0;
        last_next = last_reg;
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            S_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (sts.run_done) state_next = S_START;
                end
            end
            S_START: begin
                cmd.reg_start = 1'b1;
                state_next = S_REGS;
            end
            S_REGS: begin
                cmd.reg_step = 1'b1;
                if (sts.reg_done) state_next = S_GENE;
            end
            S_GENE: begin
                if (pend_reg) cmd.gene_cap = 1'b1;
                if (sts.chunk_full && !pend_reg) begin
                    last_next = sts.last;
                    state_next = S_OUT;
                end else if (!sts.genes_done && !(pend_reg && sts.chunk_full)) begin
                    cmd.gene_rd = 1'b1;
                    pend_next = 1'b1;
                end
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (last_reg) begin
                        cmd.clr_run = 1'b1;
                        state_next = S_LOAD;
                    end else begin
                        cmd.chunk_clr = 1'b1;
                        state_next = S_GENE;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            pend_reg <= 1'b0;
            last_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg <= pend_next;
            last_reg <= last_next;
        end
    end

    assign m_last = last_reg;

    a_no_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == S_LOAD) else $error("input taken while busy");
    a_out_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("overlap");
    a_clr_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_run |-> last_reg) else $error("clear before last chunk");
endmodule

>>> design/regulator_redundancy_pruner.sv
// Regulator redundancy pruner top level.
// Usage: gene rows arrive on s_ (one beat per cycle while loading). The beat
// that completes num_genes rows starts pruning; s_ready is low until done.
// Pruning walks regulator pairs one per cycle, then reads stored rows one per
// cycle from the row memory port (pausing while each result beat is out),
// emitting one 64-gene chunk per result beat on m_ with last_chunk on the
// final one. A stalled receiver holds the result beat and the block waits.
// Reset clears counters and state; the row memory holds garbage until written.
// Config writes are accepted at any time; cfg_ready is always high.
module regulator_redundancy_pruner #(
    parameter int MAX_REGS  = 32,
    parameter int MAX_GENES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_edge_row,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_removed_regs_mask,
    output logic [63:0] m_removed_genes_chunk,
    output logic [3:0]  m_chunk_index,
    output logic        m_last_chunk
);
    import rrp_pkg::*;

    logic [10:0] num_genes_reg;
    logic [5:0]  num_regs_reg;
    rrp_cmd_t    cmd;
    rrp_sts_t    sts;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_genes_reg <= 11'd1024;
            num_regs_reg <= 6'd32;
        end else if (cfg_valid) begin
            if (cfg_index == 1'(CFG_NUM_GENES)) num_genes_reg <= cfg_data;
            else num_regs_reg <= cfg_data[5:0];
        end
    end

    rrp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .m_last(m_last_chunk),
        .cmd(cmd), .sts(sts)
    );

    rrp_datapath #(.MAX_REGS(MAX_REGS), .MAX_GENES(MAX_GENES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .num_genes(num_genes_reg), .num_regs(num_regs_reg), .edge_row(s_edge_row),
        .removed_mask(m_removed_regs_mask), .chunk_bits(m_removed_genes_chunk),
        .chunk_idx(m_chunk_index)
    );
endmodule
